// ----- hdl/wrpp_pkg.sv -----
// Shared types and constants for the windowed ring packet producer.
package wrpp_pkg;

	localparam int RING_AW      = 16;
	localparam int HEADER_BYTES = 8;
	localparam int LEN_W        = 16;
	localparam int TOTAL_W      = LEN_W + 1;
	localparam int SUM_W        = ((RING_AW > TOTAL_W) ? RING_AW : TOTAL_W) + 1;
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = 2;

	localparam logic [SUM_W-1:0] RING_BYTES_W = SUM_W'(1) << RING_AW;

	localparam logic [1:0] ST_SENT   = 2'd0;
	localparam logic [1:0] ST_WINDOW = 2'd1;
	localparam logic [1:0] ST_LONG   = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	localparam logic [1:0] CLS_WINDOW = 2'd0;
	localparam logic [1:0] CLS_LONG   = 2'd1;
	localparam logic [1:0] CLS_SEND   = 2'd2;

	localparam logic REG_WINDOW  = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	localparam logic [15:0] WINDOW_RST  = 16'd64;
	localparam logic [15:0] MAX_LEN_RST = 16'd4096;
	localparam logic [31:0] SEQ_RST     = 32'd1;

	typedef struct packed {
		logic [7:0]  packet_kind;
		logic [15:0] payload_len;
		logic [31:0] acked_seq;
		logic [15:0] consumer_read_ptr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] assigned_seq;
		logic [15:0] write_offset;
		logic [15:0] first_len;
		logic [15:0] second_len;
		logic [31:0] drop_count;
		logic        overflow_seen;
	} rsp_t;

	typedef struct packed {
		logic [1:0]         cls;
		logic [31:0]        seq;
		logic [LEN_W-1:0]   len;
		logic [RING_AW-1:0] rptr;
	} mid_t;

endpackage

// ----- hdl/wrpp_front.sv -----
// Front part: window and length checks, sequence number assignment.
module wrpp_front
	import wrpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  req_t        req,
	input  logic [15:0] window_packets,
	input  logic [15:0] max_payload_bytes,
	output mid_t        mid
);

	logic [31:0] next_seq_q;
	logic [31:0] in_flight;
	logic        win_drop;
	logic        too_long;

	assign in_flight = next_seq_q - req.acked_seq;
	assign win_drop  = in_flight > {16'd0, window_packets};
	assign too_long  = req.payload_len > max_payload_bytes;

	always_comb begin
		mid.len  = req.payload_len;
		mid.rptr = RING_AW'(req.consumer_read_ptr);
		mid.seq  = next_seq_q;
		if (win_drop) begin
			mid.cls = CLS_WINDOW;
		end else if (too_long) begin
			mid.cls = CLS_LONG;
		end else begin
			mid.cls = CLS_SEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= SEQ_RST;
		end else if (fire && !win_drop && !too_long) begin
			next_seq_q <= next_seq_q + 32'd1;
		end
	end

endmodule

// ----- hdl/wrpp_fifo.sv -----
// Short queue of classified requests between front and back.
module wrpp_fifo
	import wrpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  mid_t wr_data,
	input  logic rd_en,
	output mid_t rd_data,
	output logic full,
	output logic empty
);

	mid_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full    = count_q == (Q_AW+1)'(Q_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (Q_AW+1)'(1);
				2'b01:   count_q <= count_q - (Q_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/wrpp_back.sv -----
// Back part: ring space check, write descriptor, drop counting, result register.
module wrpp_back
	import wrpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  mid_t mid,
	input  logic mid_empty,
	output logic mid_pop,
	output rsp_t rsp,
	output logic empty,
	input  logic pop
);

	logic [RING_AW-1:0] write_ptr_q;
	logic [31:0]        drops_q;
	logic               overflow_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic [RING_AW-1:0] free_b;
	logic [SUM_W-1:0]   total;
	logic [SUM_W-1:0]   end_pos;
	logic [SUM_W-1:0]   first_w;
	logic [SUM_W-1:0]   second_w;
	logic               fire;
	logic               count_it;
	logic               advance;
	rsp_t               res;

	assign fire    = !mid_empty && (!out_valid_q || pop);
	assign mid_pop = fire;
	assign rsp     = out_q;
	assign empty   = !out_valid_q;

	assign free_b  = mid.rptr - write_ptr_q - RING_AW'(1);
	assign total   = SUM_W'(HEADER_BYTES) + SUM_W'(mid.len);
	assign end_pos = SUM_W'(write_ptr_q) + total;

	always_comb begin
		if (end_pos <= RING_BYTES_W) begin
			first_w  = total;
			second_w = '0;
		end else begin
			first_w  = RING_BYTES_W - SUM_W'(write_ptr_q);
			second_w = total - first_w;
		end
	end

	always_comb begin
		res               = '0;
		count_it          = 1'b0;
		advance           = 1'b0;
		case (mid.cls)
			CLS_WINDOW: begin
				res.status = ST_WINDOW;
				count_it   = 1'b1;
			end
			CLS_LONG: begin
				res.status = ST_LONG;
			end
			CLS_SEND: begin
				res.assigned_seq = mid.seq;
				if (SUM_W'(free_b) < total) begin
					res.status = ST_FULL;
					count_it   = 1'b1;
				end else begin
					res.status       = ST_SENT;
					res.write_offset = 16'(write_ptr_q);
					res.first_len    = first_w[15:0];
					res.second_len   = second_w[15:0];
					advance          = 1'b1;
				end
			end
			default: begin
				res.status = ST_LONG;
			end
		endcase
		res.drop_count    = count_it ? drops_q + 32'd1 : drops_q;
		res.overflow_seen = overflow_q | count_it;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_ptr_q <= '0;
			drops_q     <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fire || (out_valid_q && !pop);
			if (fire) begin
				drops_q    <= res.drop_count;
				overflow_q <= res.overflow_seen;
				if (advance) begin
					write_ptr_q <= RING_AW'(end_pos);
				end
			end
		end
	end

	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (drops_q == $past(drops_q) + 32'd1) ==
			(out_q.status == ST_WINDOW || out_q.status == ST_FULL))
		else $error("drop count does not follow drop status");

	a_idle_desc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_SENT |->
			out_q.write_offset == '0 && out_q.first_len == '0 && out_q.second_len == '0)
		else $error("descriptor on refused packet");

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(write_ptr_q) && $stable(drops_q))
		else $error("state moved without a result");

endmodule

// ----- hdl/windowed_ring_packet_producer.sv -----
// Top level of the windowed ring packet producer with its APB register port.
//
// Requests enter through a queue-style port: a beat is taken when push is high
// and full is low. Results leave through a second queue-style port: while empty
// is low, rsp holds the oldest result and it is taken when pop is high.
// Each request gives exactly one result, in request order.
// Throughput is one request per cycle while full is low. The front checks the window
// and length and assigns the sequence number in the cycle of the push; the request is
// then held in the queue, and the back checks ring space and updates the write pointer
// and drop count when it leaves the queue, and registers its result in the result
// register, from which it can be popped.
// A four-entry queue sits between the two parts and one result register sits at
// the output; when pop stays low the result register holds, the queue fills and
// full rises after four more requests, and no beat is lost.
// Registers: window_packets at byte 0, max_payload_bytes at byte 4, 16 bits each;
// write them only while no request is in flight.
// Reset (arst_n low) sets the next sequence number to 1, the write pointer, drop
// count and overflow flag to 0, empties both queues and restores the registers to
// 64 and 4096.
module windowed_ring_packet_producer
	import wrpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  req_t        req,
	output logic        empty,
	input  logic        pop,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] window_q;
	logic [15:0] max_len_q;
	logic        cfg_wr;
	logic        in_fire;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	mid_t        mid_in;
	mid_t        mid_out;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_q} : {16'd0, window_q};
	assign full    = q_full;
	assign in_fire = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WINDOW_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WINDOW) begin
				window_q <= pwdata[15:0];
			end else begin
				max_len_q <= pwdata[15:0];
			end
		end
	end

	wrpp_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (in_fire),
		.req               (req),
		.window_packets    (window_q),
		.max_payload_bytes (max_len_q),
		.mid               (mid_in)
	);

	wrpp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_fire),
		.wr_data (mid_in),
		.rd_en   (q_pop),
		.rd_data (mid_out),
		.full    (q_full),
		.empty   (q_empty)
	);

	wrpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid       (mid_out),
		.mid_empty (q_empty),
		.mid_pop   (q_pop),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
